/* rtl/tss_pkg.sv */
// types, constants and fixed-point helpers for the scanline span unit
package tss_pkg;

    localparam int CW = 16;          // vertex coordinate width
    localparam int FB = 4;           // coordinate fraction bits
    localparam int GB = 16;          // extra fraction bits on edge crossings
    localparam int RW = 12;          // row and pixel width
    localparam int QW = CW + GB;     // quotient bits of the edge divider
    localparam int PW = CW + GB + 2; // working width of crossings and compares

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [RW-1:0] pix_t;
    typedef logic signed [PW-1:0] wide_t;

    localparam wide_t PIX_MIN = -(wide_t'(1) <<< (RW - 1));
    localparam wide_t PIX_MAX = (wide_t'(1) <<< (RW - 1)) - wide_t'(1);

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by_coord;
        coord_t cx;
        coord_t cy;
        pix_t   row;
    } tss_req_t;

    typedef struct packed {
        logic draw;
        pix_t span_row;
        pix_t x_start;
        pix_t x_end;
    } tss_span_t;

    // per-row data that rides alongside the edge dividers
    typedef struct packed {
        logic                 active;
        logic                 mrow;
        logic                 edge_row;
        logic [1:0]           neg;
        logic [1:0][CW-1:0]   den;
        logic [1:0][CW-1:0]   base;
        coord_t               lft;
        coord_t               rght;
        coord_t               xmx;
        pix_t                 xm_rnd;
        pix_t                 row;
    } tss_side_t;

    function automatic wide_t ext_c(coord_t v);
        return wide_t'(v);
    endfunction

    function automatic wide_t ceil_fix(coord_t y);
        return (wide_t'(y) + wide_t'((1 << FB) - 1)) >>> FB;
    endfunction

    function automatic wide_t floor_fix(coord_t y);
        return wide_t'(y) >>> FB;
    endfunction

    // round to nearest, ties away from zero
    function automatic wide_t round_fix(wide_t v, int unsigned sh);
        wide_t mag;
        wide_t half;
        wide_t r;
        half = (sh == 0) ? wide_t'(0) : (wide_t'(1) <<< (sh - 1));
        mag  = (v < 0) ? -v : v;
        r    = (mag + half) >>> sh;
        return (v < 0) ? -r : r;
    endfunction

    function automatic pix_t sat_pix(wide_t v);
        wide_t s;
        s = v;
        if (v < PIX_MIN)
            s = PIX_MIN;
        else if (v > PIX_MAX)
            s = PIX_MAX;
        return s[RW-1:0];
    endfunction

endpackage

/* rtl/triangle_scanline_span.sv */
// scanline triangle span unit: one row request in, one span word out
//
// One request word is taken on every clock (busy stays low) and its span word
// appears on span, marked by done, after passing the sort, edge, product, divider,
// rounding, clamp, middle-vertex and output registers. Both edge dividers
// produce one quotient bit per pipeline stage. Results come out in request
// order, one per request, and must be captured in the cycle done is high.
module triangle_scanline_span (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tss_pkg::tss_req_t req,
    output logic              done,
    output tss_pkg::tss_span_t span
);
    import tss_pkg::*;

    localparam int LAT = QW + 7;

    // ---------------- stage 1: stable sorts by y and by x
    coord_t     xv [3];
    coord_t     yv [3];
    logic [1:0] oy [3];
    logic [1:0] ox [3];
    logic [1:0] tmp_i;

    logic   v1_reg;
    coord_t tx_reg, ty_reg, mx_reg, my_reg, bx_reg, by_reg;
    coord_t xl_reg, xr_reg, xmx_reg, xmy_reg;
    pix_t   row1_reg;

    always_comb
    begin
        xv[0] = req.ax;
        yv[0] = req.ay;
        xv[1] = req.bx;
        yv[1] = req.by_coord;
        xv[2] = req.cx;
        yv[2] = req.cy;
        oy[0] = 2'd0;
        oy[1] = 2'd1;
        oy[2] = 2'd2;
        ox[0] = 2'd0;
        ox[1] = 2'd1;
        ox[2] = 2'd2;
        tmp_i = 2'd0;
        if (yv[oy[0]] > yv[oy[1]])
        begin
            tmp_i = oy[0]; oy[0] = oy[1]; oy[1] = tmp_i;
        end
        if (yv[oy[1]] > yv[oy[2]])
        begin
            tmp_i = oy[1]; oy[1] = oy[2]; oy[2] = tmp_i;
        end
        if (yv[oy[0]] > yv[oy[1]])
        begin
            tmp_i = oy[0]; oy[0] = oy[1]; oy[1] = tmp_i;
        end
        if (xv[ox[0]] > xv[ox[1]])
        begin
            tmp_i = ox[0]; ox[0] = ox[1]; ox[1] = tmp_i;
        end
        if (xv[ox[1]] > xv[ox[2]])
        begin
            tmp_i = ox[1]; ox[1] = ox[2]; ox[2] = tmp_i;
        end
        if (xv[ox[0]] > xv[ox[1]])
        begin
            tmp_i = ox[0]; ox[0] = ox[1]; ox[1] = tmp_i;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg   <= xv[oy[0]];
        ty_reg   <= yv[oy[0]];
        mx_reg   <= xv[oy[1]];
        my_reg   <= yv[oy[1]];
        bx_reg   <= xv[oy[2]];
        by_reg   <= yv[oy[2]];
        xl_reg   <= xv[ox[0]];
        xr_reg   <= xv[ox[2]];
        xmx_reg  <= xv[ox[1]];
        xmy_reg  <= yv[ox[1]];
        row1_reg <= req.row;
    end

    // ---------------- stage 2: row ranges, edge selection, edge deltas
    wide_t     i_w, i_fx;
    logic      upper_next, lower_next;
    coord_t    e0x0, e0y0, e0x1, e0y1;
    wide_t     num_w [2];
    wide_t     den_w [2];
    wide_t     dx_w  [2];
    wide_t     dxa_w [2];
    tss_side_t side_next;

    logic            v2_reg;
    logic [CW-1:0]   nm_reg [2];
    logic [CW-1:0]   dm_reg [2];
    tss_side_t       side2_reg;

    always_comb
    begin
        i_w  = wide_t'(row1_reg);
        i_fx = i_w <<< FB;
        upper_next = (i_w >= ceil_fix(ty_reg)) && (i_w < ceil_fix(my_reg));
        lower_next = !upper_next && (i_w >= ceil_fix(my_reg)) && (i_w < floor_fix(by_reg));
        e0x0 = upper_next ? tx_reg : mx_reg;
        e0y0 = upper_next ? ty_reg : my_reg;
        e0x1 = upper_next ? mx_reg : bx_reg;
        e0y1 = upper_next ? my_reg : by_reg;
        num_w[0] = i_fx - ext_c(e0y0);
        den_w[0] = ext_c(e0y1) - ext_c(e0y0);
        dx_w[0]  = ext_c(e0x1) - ext_c(e0x0);
        num_w[1] = i_fx - ext_c(ty_reg);
        den_w[1] = ext_c(by_reg) - ext_c(ty_reg);
        dx_w[1]  = ext_c(bx_reg) - ext_c(tx_reg);
        dxa_w[0] = (dx_w[0] < 0) ? -dx_w[0] : dx_w[0];
        dxa_w[1] = (dx_w[1] < 0) ? -dx_w[1] : dx_w[1];

        side_next.active   = upper_next || lower_next;
        side_next.mrow     = (i_w == round_fix(ext_c(xmy_reg), FB));
        side_next.edge_row = upper_next ? (i_w <= round_fix(ext_c(ty_reg), FB))
                                        : (i_w >= round_fix(ext_c(by_reg), FB));
        side_next.neg[0]   = dx_w[0] < 0;
        side_next.neg[1]   = dx_w[1] < 0;
        side_next.den[0]   = den_w[0][CW-1:0];
        side_next.den[1]   = den_w[1][CW-1:0];
        side_next.base[0]  = e0x0;
        side_next.base[1]  = tx_reg;
        side_next.lft      = xl_reg;
        side_next.rght     = xr_reg;
        side_next.xmx      = xmx_reg;
        side_next.xm_rnd   = sat_pix(round_fix(ext_c(xmx_reg), FB));
        side_next.row      = row1_reg;
    end

    always_ff @(posedge clk)
    begin
        nm_reg[0] <= num_w[0][CW-1:0];
        nm_reg[1] <= num_w[1][CW-1:0];
        dm_reg[0] <= dxa_w[0][CW-1:0];
        dm_reg[1] <= dxa_w[1][CW-1:0];
        side2_reg <= side_next;
    end

    // ---------------- stage 3: products, then one quotient bit per stage
    logic [2*CW-1:0] prod_next [2];
    logic            vd_reg   [0:QW];
    tss_side_t       sided_reg [0:QW];
    logic [CW-1:0]   rem_reg  [2][0:QW];
    logic [QW-1:0]   acc_reg  [2][0:QW];

    always_comb
    begin
        prod_next[0] = nm_reg[0] * dm_reg[0];
        prod_next[1] = nm_reg[1] * dm_reg[1];
    end

    always_ff @(posedge clk)
    begin
        sided_reg[0]  <= side2_reg;
        rem_reg[0][0] <= prod_next[0][2*CW-1:CW];
        rem_reg[1][0] <= prod_next[1][2*CW-1:CW];
        acc_reg[0][0] <= {prod_next[0][CW-1:0], {GB{1'b0}}};
        acc_reg[1][0] <= {prod_next[1][CW-1:0], {GB{1'b0}}};
    end

    genvar e, s;
    generate
        for (s = 1; s <= QW; s++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                sided_reg[s] <= sided_reg[s-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vd_reg[s] <= 1'b0;
                else
                    vd_reg[s] <= vd_reg[s-1];
            end
        end
        for (e = 0; e < 2; e++)
        begin : g_edge
            for (s = 1; s <= QW; s++)
            begin : g_bit
                logic [CW:0]   trial;
                logic [CW:0]   dsor;
                logic          ge;
                logic [CW:0]   rem_next;
                logic [QW-1:0] acc_next;
                always_comb
                begin
                    trial    = {rem_reg[e][s-1], acc_reg[e][s-1][QW-1]};
                    dsor     = {1'b0, sided_reg[s-1].den[e]};
                    ge       = trial >= dsor;
                    rem_next = ge ? (trial - dsor) : trial;
                    acc_next = {acc_reg[e][s-1][QW-2:0], ge};
                end
                always_ff @(posedge clk)
                begin
                    rem_reg[e][s] <= rem_next[CW-1:0];
                    acc_reg[e][s] <= acc_next;
                end
            end
        end
    endgenerate

    // ---------------- round the quotients and form the crossings
    wide_t     p_next [2];
    logic      vr_reg;
    wide_t     pr_reg [2];
    tss_side_t sider_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            logic [QW:0] q;
            wide_t       bw;
            q  = {1'b0, acc_reg[k][QW]} +
                 (({rem_reg[k][QW], 1'b0} >= {1'b0, sided_reg[QW].den[k]}) ?
                  (QW+1)'(1) : (QW+1)'(0));
            bw = ext_c(coord_t'(sided_reg[QW].base[k])) <<< GB;
            p_next[k] = sided_reg[QW].neg[k] ? (bw - wide_t'(q)) : (bw + wide_t'(q));
        end
    end

    always_ff @(posedge clk)
    begin
        pr_reg[0] <= p_next[0];
        pr_reg[1] <= p_next[1];
        sider_reg <= sided_reg[QW];
    end

    // ---------------- order the ends and clamp to the box
    wide_t     lo_next, hi_next, lftw, rghtw;
    logic      vf1_reg;
    wide_t     lo1_reg, hi1_reg;
    tss_side_t side_f1_reg;

    always_comb
    begin
        lftw    = ext_c(sider_reg.lft) <<< GB;
        rghtw   = ext_c(sider_reg.rght) <<< GB;
        lo_next = (pr_reg[0] > pr_reg[1]) ? pr_reg[1] : pr_reg[0];
        hi_next = (pr_reg[0] > pr_reg[1]) ? pr_reg[0] : pr_reg[1];
        if (lo_next < lftw)
            lo_next = lftw;
        if (hi_next > rghtw)
            hi_next = rghtw;
    end

    always_ff @(posedge clk)
    begin
        lo1_reg     <= lo_next;
        hi1_reg     <= hi_next;
        side_f1_reg <= sider_reg;
    end

    // ---------------- middle vertex row rule
    wide_t mlx, d1, d2;
    logic  c1, outward, suppress, chg1_next, chg2_next;
    logic  vf2_reg, draw2_reg, chg1_reg, chg2_reg;
    wide_t lo2_reg, hi2_reg;
    pix_t  xm2_reg, row2_reg;

    always_comb
    begin
        mlx       = ext_c(side_f1_reg.xmx) <<< GB;
        d1        = mlx - lo1_reg;
        d2        = mlx - hi1_reg;
        d1        = (d1 < 0) ? -d1 : d1;
        d2        = (d2 < 0) ? -d2 : d2;
        c1        = d1 < d2;
        outward   = c1 ? (lo1_reg < mlx) : (hi1_reg > mlx);
        suppress  = side_f1_reg.mrow && outward && side_f1_reg.edge_row;
        chg1_next = side_f1_reg.mrow && outward && !side_f1_reg.edge_row && c1;
        chg2_next = side_f1_reg.mrow && outward && !side_f1_reg.edge_row && !c1;
    end

    always_ff @(posedge clk)
    begin
        draw2_reg <= side_f1_reg.active && !suppress;
        chg1_reg  <= chg1_next;
        chg2_reg  <= chg2_next;
        lo2_reg   <= lo1_reg;
        hi2_reg   <= hi1_reg;
        xm2_reg   <= side_f1_reg.xm_rnd;
        row2_reg  <= side_f1_reg.row;
    end

    // ---------------- round to pixels and saturate
    tss_span_t span_next;
    logic      done_reg;
    tss_span_t span_reg;

    always_comb
    begin
        span_next.draw     = draw2_reg;
        span_next.span_row = row2_reg;
        span_next.x_start  = '0;
        span_next.x_end    = '0;
        if (draw2_reg)
        begin
            span_next.x_start = chg1_reg ? xm2_reg : sat_pix(round_fix(lo2_reg, FB + GB));
            span_next.x_end   = chg2_reg ? xm2_reg : sat_pix(round_fix(hi2_reg, FB + GB));
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vd_reg[0] <= 1'b0;
            vr_reg    <= 1'b0;
            vf1_reg   <= 1'b0;
            vf2_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            vr_reg    <= vd_reg[QW];
            vf1_reg   <= vr_reg;
            vf2_reg   <= vf1_reg;
            done_reg  <= vf2_reg;
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign span = span_reg;

    // a result word only follows an earlier request word
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("span word without matching request");

    a_row_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> span.span_row == $past(req.row, LAT))
        else $error("span row does not match request row");

    a_nodraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !span.draw) |-> (span.x_start == '0 && span.x_end == '0))
        else $error("ends not cleared on a row without a span");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the scanline triangle span unit
`timescale 1ns / 1ps

module testbench;
    import tss_pkg::*;

    localparam int LATENCY  = 39;
    localparam int N_RANDOM = 1750;
    localparam int WATCHDOG = 2000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    tss_req_t  req;
    logic      done;
    tss_span_t span;

    triangle_scanline_span dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .span  (span)
    );

    tss_span_t span_queue[$];
    int        error_count;
    int        idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint fl4(longint v);
        return v >>> 4;
    endfunction

    function automatic longint ce4(longint v);
        return -((-v) >>> 4);
    endfunction

    function automatic longint rnd_sh(longint v, int sh);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + ((longint'(1) << sh) >>> 1)) >>> sh;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clamp12(longint v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    // crossing x with 20 fraction bits, quotient rounded half up in magnitude
    function automatic longint cross_x(longint x0, longint y0, longint x1, longint y1,
                                       longint r);
        longint base;
        longint num;
        longint den;
        longint dx;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] rem;
        base = x0 <<< 16;
        num = (r <<< 4) - y0;
        den = y1 - y0;
        dx = x1 - x0;
        if (den <= 0 || num == 0 || dx == 0)
            return base;
        prod = 128'((num < 0) ? -num : num) * (128'((dx < 0) ? -dx : dx) << 16);
        q = prod / 128'(den);
        rem = prod % 128'(den);
        if (rem >= 128'(den) - rem)
            q = q + 1;
        if ((num < 0) != (dx < 0))
            return base - longint'(q);
        return base + longint'(q);
    endfunction

    function automatic void order3(longint k[3], ref int o[3]);
        int t;
        if (k[o[0]] > k[o[1]]) begin t = o[0]; o[0] = o[1]; o[1] = t; end
        if (k[o[1]] > k[o[2]]) begin t = o[1]; o[1] = o[2]; o[2] = t; end
        if (k[o[0]] > k[o[1]]) begin t = o[0]; o[0] = o[1]; o[1] = t; end
    endfunction

    function automatic tss_span_t predict_span(tss_req_t rq);
        longint    vx[3];
        longint    vy[3];
        int        oy[3];
        int        ox[3];
        longint    r, p1, p2, t, lft, rght, mlx, d1, d2, xs, xe;
        int        top, mid, bot, xm, chg;
        bit        upper, lower, dr, supp, outward, edge_row;
        tss_span_t s;
        vx[0] = longint'(rq.ax); vy[0] = longint'(rq.ay);
        vx[1] = longint'(rq.bx); vy[1] = longint'(rq.by_coord);
        vx[2] = longint'(rq.cx); vy[2] = longint'(rq.cy);
        r = longint'(rq.row);
        oy = '{0, 1, 2};
        ox = '{0, 1, 2};
        order3(vy, oy);
        order3(vx, ox);
        top = oy[0]; mid = oy[1]; bot = oy[2]; xm = ox[1];
        lft = vx[ox[0]] <<< 16;
        rght = vx[ox[2]] <<< 16;
        mlx = vx[xm] <<< 16;
        upper = r >= ce4(vy[top]) && r < ce4(vy[mid]);
        lower = !upper && r >= ce4(vy[mid]) && r < fl4(vy[bot]);
        dr = 0; supp = 0; chg = 0; xs = 0; xe = 0;
        if (upper || lower)
        begin
            if (upper)
                p1 = cross_x(vx[top], vy[top], vx[mid], vy[mid], r);
            else
                p1 = cross_x(vx[mid], vy[mid], vx[bot], vy[bot], r);
            p2 = cross_x(vx[top], vy[top], vx[bot], vy[bot], r);
            if (p1 > p2) begin t = p1; p1 = p2; p2 = t; end
            if (p1 < lft) p1 = lft;
            if (p2 > rght) p2 = rght;
            d1 = mlx - p1; if (d1 < 0) d1 = -d1;
            d2 = mlx - p2; if (d2 < 0) d2 = -d2;
            if (r == rnd_sh(vy[xm], 4))
            begin
                outward = (d1 < d2) ? (p1 < mlx) : (p2 > mlx);
                if (outward)
                begin
                    edge_row = upper ? (r <= rnd_sh(vy[top], 4)) : (r >= rnd_sh(vy[bot], 4));
                    if (edge_row)
                        supp = 1;
                    else
                        chg = (d1 < d2) ? 1 : 2;
                end
            end
            if (!supp)
            begin
                dr = 1;
                xs = clamp12(chg == 1 ? rnd_sh(vx[xm], 4) : rnd_sh(p1, 20));
                xe = clamp12(chg == 2 ? rnd_sh(vx[xm], 4) : rnd_sh(p2, 20));
            end
        end
        s.draw = dr;
        s.span_row = rq.row;
        s.x_start = pix_t'(xs);
        s.x_end = pix_t'(xe);
        return s;
    endfunction

    // rising edge: sample accepted words and results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy)
                span_queue.push_back(predict_span(req));
            if (done)
            begin
                if (span_queue.size() == 0)
                begin
                    $error("span word with nothing expected");
                    error_count++;
                end
                else
                begin
                    tss_span_t e;
                    e = span_queue.pop_front();
                    if (span.draw !== e.draw)
                    begin
                        $error("draw: expected %0d, got %0d", e.draw, span.draw);
                        error_count++;
                    end
                    if (span.span_row !== e.span_row)
                    begin
                        $error("span_row: expected %0d, got %0d", e.span_row, span.span_row);
                        error_count++;
                    end
                    if (span.x_start !== e.x_start)
                    begin
                        $error("x_start: expected %0d, got %0d", e.x_start, span.x_start);
                        error_count++;
                    end
                    if (span.x_end !== e.x_end)
                    begin
                        $error("x_end: expected %0d, got %0d", e.x_end, span.x_end);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    typedef struct {
        tss_req_t  rq;
        bit        known;
        tss_span_t want;
    } stim_row_t;

    stim_row_t stim_table[$];

    function automatic tss_req_t mk(int ax, int ay, int bx, int by, int cx, int cy, int r);
        tss_req_t q;
        q.ax = coord_t'(ax); q.ay = coord_t'(ay);
        q.bx = coord_t'(bx); q.by_coord = coord_t'(by);
        q.cx = coord_t'(cx); q.cy = coord_t'(cy);
        q.row = pix_t'(r);
        return q;
    endfunction

    function automatic void add_row(tss_req_t q, bit known, bit dr, int xs, int xe);
        stim_row_t s;
        s.rq = q;
        s.known = known;
        s.want.draw = dr;
        s.want.span_row = q.row;
        s.want.x_start = pix_t'(xs);
        s.want.x_end = pix_t'(xe);
        stim_table.push_back(s);
    endfunction

    function automatic int rc();
        return $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom)))
                                          : $urandom_range(0, 1600) - 800;
    endfunction

    task automatic send(tss_req_t q, bit gaps);
        if (gaps && $urandom_range(0, 7) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        start <= 1'b1;
        req <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        tss_req_t q;
        int       tmo;
        int       y0;
        int       ya;
        int       yb;
        error_count = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // row outside the triangle, all-zero triangle, extremes
        add_row(mk(0, 0, 160, 0, 0, 160, 20), 1, 0, 0, 0);
        add_row(mk(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
        add_row(mk(0, 0, 0, 0, 0, 0, -2048), 1, 0, 0, 0);
        add_row(mk(-32768, -32768, 32767, -32768, 0, 32767, 2047), 1, 0, 0, 0);
        add_row(mk(-32768, -32768, 32767, -32768, 0, 32767, 0), 1, 1, -1024, 1024);
        add_row(mk(-32768, -32768, -32768, 32767, -32768, 0, -2048), 0, 0, 0, 0);
        add_row(mk(32767, 32767, -32768, -32768, 32767, -32768, -1000), 0, 0, 0, 0);
        add_row(mk(0, 0, 160, 0, 0, 160, 5), 0, 0, 0, 0);
        // flat top and flat bottom, repeated vertices
        add_row(mk(0, 0, 160, 0, 80, 160, 0), 0, 0, 0, 0);
        add_row(mk(0, 0, 160, 0, 80, 160, 9), 0, 0, 0, 0);
        add_row(mk(80, 0, 0, 160, 160, 160, 9), 0, 0, 0, 0);
        add_row(mk(80, 0, 80, 0, 160, 160, 3), 0, 0, 0, 0);
        add_row(mk(50, 50, 50, 50, 50, 50, 3), 0, 0, 0, 0);
        // middle vertex row: end replaced by vertex x, and suppressed span
        add_row(mk(0, 0, 200, 40, 40, 160, 3), 0, 0, 0, 0);
        add_row(mk(0, 0, -200, 40, 40, 160, 3), 0, 0, 0, 0);
        add_row(mk(0, 4, 200, 6, 40, 160, 0), 0, 0, 0, 0);
        add_row(mk(0, 0, 200, 150, 40, 156, 9), 0, 0, 0, 0);
        add_row(mk(0, 0, 200, 150, 40, 156, 10), 0, 0, 0, 0);
        add_row(mk(8, 8, 24, 24, 40, 8, 1), 0, 0, 0, 0);
        add_row(mk(-1, -1, 1, 1, 7, 9, 0), 0, 0, 0, 0);

        foreach (stim_table[k])
        begin
            if (stim_table[k].known)
                if (predict_span(stim_table[k].rq) !== stim_table[k].want)
                begin
                    $error("table row %0d: prediction disagrees with typed value", k);
                    error_count++;
                end
            send(stim_table[k].rq, 1);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: random bits, but the top bits of ax stay zero
                q = tss_req_t'({$urandom, $urandom, $urandom});
            end
            else
            begin
                q = mk(rc(), rc(), rc(), rc(), rc(), rc(), 0);
                ya = q.ay < q.by_coord ? q.ay : q.by_coord;
                ya = ya < q.cy ? ya : int'(q.cy);
                yb = q.ay > q.by_coord ? q.ay : q.by_coord;
                yb = yb > q.cy ? yb : int'(q.cy);
                y0 = $urandom_range(0, (yb >>> 4) - (ya >>> 4) + 2) + (ya >>> 4) - 1;
                q.row = pix_t'(y0);
            end
            send(q, n < N_RANDOM - 200);
        end
        start <= 1'b0;

        tmo = 0;
        while (span_queue.size() != 0 && tmo < WATCHDOG)
        begin
            @(negedge clk);
            tmo++;
        end
        repeat (LATENCY + 5) @(negedge clk);
        if (span_queue.size() == 0 && error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
